// ----- src/tcw_pkg.sv -----
// shared types and constants for the text console cell writer
// no dependencies; imported by tcw_cursor, the top level and the checker
`default_nettype none

package tcw_pkg;

  // default geometry
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // field widths
  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = ATTR_W + CHAR_W;

  localparam logic [ATTR_W-1:0] FILL_COLOR_RST = 8'd15;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT_CURSOR   = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT_POS      = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_CURSOR   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_SCREEN = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ROW    = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_CELL    = 3'd5;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } out_item_t;

  // outcome of one put at cursor
  typedef struct packed {
    logic              wr_en;
    logic [COL_W-1:0]  wr_col;
    logic [CHAR_W-1:0] wr_char;
    logic [COL_W-1:0]  new_col;
    logic [ROW_W-1:0]  new_row;
    logic              scroll;
  } cur_step_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_COPY,
    ST_COPY_LAST,
    ST_FILL,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ----- src/tcw_ram.sv -----
// screen cell store: one write port, one read port, registered read data
// depends on nothing but its parameters
`default_nettype none

module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] cells_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cells_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/tcw_cursor.sv -----
// cursor advance for put at cursor: control codes, wrap and scroll decision
// depends on tcw_pkg
`default_nettype none

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  wire logic [COL_W-1:0]  cur_col,
  input  wire logic [ROW_W-1:0]  cur_row,
  input  wire logic [CHAR_W-1:0] char_code,
  output cur_step_t              step
);

  localparam int TAB_ENTRIES = 2 ** COL_W;

  // next tab stop for every column value
  logic [COL_W:0] tab_next [TAB_ENTRIES];

  for (genvar g = 0; g < TAB_ENTRIES; g++) begin : g_tab
    assign tab_next[g] = (COL_W + 1)'(g + TAB_STOP - (g % TAB_STOP));
  end

  always_comb begin
    logic [COL_W:0] col_w;
    logic [ROW_W:0] row_w;
    col_w        = {1'b0, cur_col};
    row_w        = {1'b0, cur_row};
    step.wr_en   = 1'b0;
    step.wr_col  = cur_col;
    step.wr_char = char_code;
    step.scroll  = 1'b0;
    case (char_code)
      CHAR_NL: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      CHAR_CR: begin
        col_w = '0;
      end
      CHAR_TAB: begin
        col_w = tab_next[cur_col];
      end
      CHAR_BS: begin
        if (cur_col != '0) begin
          col_w        = col_w - 1'b1;
          step.wr_en   = 1'b1;
          step.wr_col  = cur_col - 1'b1;
          step.wr_char = CHAR_SPACE;
        end
      end
      default: begin
        step.wr_en = 1'b1;
        col_w      = col_w + 1'b1;
      end
    endcase
    // wrap at the right edge
    if (col_w >= (COL_W + 1)'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    // past the bottom: scroll and stay on the last row
    if (row_w >= (ROW_W + 1)'(ROWS)) begin
      step.scroll = 1'b1;
      row_w       = (ROW_W + 1)'(ROWS - 1);
    end
    step.new_col = col_w[COL_W-1:0];
    step.new_row = row_w[ROW_W-1:0];
  end

endmodule

`default_nettype wire

// ----- src/text_console_cell_writer_unit.sv -----
// text console cell writer: command port, cursor, cell store sequencer
// depends on tcw_pkg, tcw_ram and tcw_cursor
// a command passes the decode and result states before the result strobe; that is all for put,
// set cursor, off-screen positions and unused codes, an on-screen read adds a read state, clear
// row fills one row and clear screen every cell, and a put that scrolls adds a copy of each cell
// one row up and a fill of the bottom row, with one store read and one write a cycle
// handshake: a new transfer is taken in the strobe cycle, one command at a time
// after reset busy stays high through the zero sweep of every cell; results cannot stall
`default_nettype none

module text_console_cell_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // command channel
  input  wire logic              start,
  input  wire in_item_t          in_data,
  output logic                   busy,
  // result strobe
  output logic                   out_valid,
  output out_item_t              out_data,
  // scroll fill colour register
  input  wire logic              cfg_valid,
  input  wire logic [ATTR_W-1:0] cfg_data,
  output logic                   cfg_ready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);   // walk pointer can hold CELLS

  // control state
  state_t            state_r,      state_nxt;
  logic [CW-1:0]     ptr_r,        ptr_nxt;
  logic [COL_W-1:0]  cur_col_r,    cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r,    cur_row_nxt;
  logic [ATTR_W-1:0] fill_color_r;
  logic              out_valid_r,  out_valid_nxt;

  // payload
  in_item_t          item_r,       item_nxt;
  logic [CW-1:0]     end_r,        end_nxt;
  logic [CELL_W-1:0] fill_val_r,   fill_val_nxt;
  logic [CELL_W-1:0] data_r,       data_nxt;
  out_item_t         out_data_r,   out_data_nxt;

  // store ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  cur_step_t         step;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [CW-1:0]     row_base;
  logic [CW-1:0]     lin_addr;
  logic [CW-1:0]     copy_dst;
  logic              pos_ok;
  logic              row_ok;

  tcw_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .char_code (item_r.char_code),
    .step      (step)
  );

  // cell address: the cursor cell (the one left of it for a backspace) for put at cursor, else the given position
  assign sel_row  = (item_r.operation == OP_PUT_CURSOR) ? cur_row_r   : item_r.pos_row;
  assign sel_col  = (item_r.operation == OP_PUT_CURSOR) ? step.wr_col : item_r.pos_col;
  assign row_base = CW'(int'(sel_row) * COLUMNS);
  assign lin_addr = row_base + CW'(sel_col);
  // scroll copy writes one row up, in the cycle after the read of that cell
  assign copy_dst = ptr_r - CW'(COLUMNS + 1);

  assign row_ok = int'(item_r.pos_row) < ROWS;
  assign pos_ok = row_ok && (int'(item_r.pos_col) < COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      ptr_r        <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      fill_color_r <= FILL_COLOR_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        fill_color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    end_r      <= end_nxt;
    fill_val_r <= fill_val_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    out_valid_nxt = 1'b0;
    item_nxt      = item_r;
    end_nxt       = end_r;
    fill_val_nxt  = fill_val_r;
    data_nxt      = data_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = lin_addr[AW-1:0];
    wr_data       = {item_r.attr, item_r.char_code};
    rd_en         = 1'b0;
    rd_addr       = lin_addr[AW-1:0];

    case (state_r)
      // zero sweep after reset
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          data_nxt  = '0;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_RESULT;
        case (item_r.operation)
          OP_PUT_CURSOR: begin
            wr_en       = step.wr_en;
            wr_data     = {item_r.attr, step.wr_char};
            cur_col_nxt = step.new_col;
            cur_row_nxt = step.new_row;
            if (step.scroll) begin
              ptr_nxt   = CW'(COLUMNS);
              state_nxt = ST_COPY;
            end
          end
          OP_PUT_POS: begin
            wr_en = pos_ok;
          end
          OP_SET_CURSOR: begin
            if (pos_ok) begin
              cur_col_nxt = item_r.pos_col;
              cur_row_nxt = item_r.pos_row;
            end
          end
          OP_CLEAR_SCREEN: begin
            ptr_nxt      = '0;
            end_nxt      = CW'(CELLS);
            fill_val_nxt = {item_r.attr, CHAR_SPACE};
            cur_col_nxt  = '0;
            cur_row_nxt  = '0;
            state_nxt    = ST_FILL;
          end
          OP_CLEAR_ROW: begin
            if (row_ok) begin
              ptr_nxt      = row_base;
              end_nxt      = row_base + CW'(COLUMNS);
              fill_val_nxt = {item_r.attr, CHAR_SPACE};
              state_nxt    = ST_FILL;
            end
          end
          OP_READ_CELL: begin
            if (pos_ok) begin
              rd_en     = 1'b1;
              state_nxt = ST_READ;
            end
          end
          default: begin
            state_nxt = ST_RESULT;
          end
        endcase
      end

      // registered read data is back
      ST_READ: begin
        data_nxt  = rd_data;
        state_nxt = ST_RESULT;
      end

      // scroll: read cell k+COLUMNS, write it to cell k on the next cycle
      ST_COPY: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r[AW-1:0];
        if (ptr_r != CW'(COLUMNS)) begin
          wr_en   = 1'b1;
          wr_addr = copy_dst[AW-1:0];
          wr_data = rd_data;
        end
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(CELLS - 1)) begin
          state_nxt = ST_COPY_LAST;
        end
      end

      // drain the last copied cell, then blank the bottom row
      ST_COPY_LAST: begin
        wr_en        = 1'b1;
        wr_addr      = copy_dst[AW-1:0];
        wr_data      = rd_data;
        ptr_nxt      = CW'((ROWS - 1) * COLUMNS);
        end_nxt      = CW'(CELLS);
        fill_val_nxt = {fill_color_r, CHAR_SPACE};
        state_nxt    = ST_FILL;
      end

      // write fill_val over [ptr, end)
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = fill_val_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == end_r - 1'b1) begin
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.cell_data  = data_r;
        out_data_nxt.cursor_col = cur_col_r;
        out_data_nxt.cursor_row = cur_row_r;
        state_nxt               = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  // the fill colour register takes a transfer in any state
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- src/tcw_checker.sv -----
// port-level checks for the text console cell writer, bound to the top level
// depends on tcw_pkg and text_console_cell_writer_unit
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // a command transfer makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  // busy only rises on a command transfer
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

  // the result strobe lasts one cycle and closes a busy period
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a command");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.cursor_col) < COLUMNS) && (int'(out_data.cursor_row) < ROWS))
    else $error("cursor outside the screen");

endmodule

bind text_console_cell_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
